@@ hw/rtl/itrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to radix digits: shared package
// Constants, sequencer states and digit helpers for the radix conversion unit.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN       = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO       = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = 7'h57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROW,
    ST_LOAD,
    ST_COUNT
  } state_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_TEN) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_ALPHA_BASE + {1'b0, d};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/integer_to_radix_digits_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to radix digits unit
// Converts one unsigned integer into ASCII digits of a configurable base.
// ----------------------------------------------------------------------------
// Usage: an input word (in_value) is taken on in_valid and in_ready. The unit
// then emits one output word per digit, most significant first, on out_valid
// and out_ready; out_last_digit marks the final digit. Zero gives one '0'.
// The base is written through cfg_we and cfg_wdata; the user must do so only
// while the unit is idle, as the block itself does not enforce it. Values
// below two or above thirty-six act as two and thirty-six. An accepted word
// first builds a table of the powers of the base up to the value in a small
// memory; then for each digit of value d the unit reads its power, subtracts
// it d times in the shared subtractor and then emits the digit. in_ready
// returns as the last digit enters the output register.
// A stalled receiver holds the output register, and the sequencer waits with
// the next digit until that register is free.
// Reset clears the sequencer and the output valid flag and sets the base to ten.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit
  import itrd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire [RADIX_W-1:0]       cfg_wdata,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [VALUE_WIDTH-1:0]   in_value,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [CHAR_W-1:0]       out_digit_char,
  output logic                    out_last_digit
);

  localparam int KW = $clog2(VALUE_WIDTH);
  localparam int PW = VALUE_WIDTH + RADIX_W;

  state_t state_r, state_nxt;

  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] pow_r, pow_nxt;
  logic [VALUE_WIDTH-1:0] pq_r;
  logic [KW-1:0]          idx_r, idx_nxt;
  logic [DIGIT_W-1:0]     dig_r, dig_nxt;
  logic                   ov_r, ov_nxt;
  logic [CHAR_W-1:0]      oc_r, oc_nxt;
  logic                   ol_r, ol_nxt;

  logic [VALUE_WIDTH-1:0] pow_mem [VALUE_WIDTH];

  logic [PW-1:0] prod;
  logic          grow_ok;
  logic          fits;
  logic          emit;
  logic          accept;

  assign prod    = PW'(pow_r) * PW'(base_r);
  assign grow_ok = (prod <= PW'(rem_r));
  assign fits    = (rem_r >= pq_r);
  assign accept  = in_valid && in_ready;
  assign emit    = (state_r == ST_COUNT) && !fits && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_GROW;
        end
      end
      ST_GROW: begin
        if (!grow_ok) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        if (emit) begin
          state_nxt = (idx_r == '0) ? ST_IDLE : ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    radix_nxt = cfg_we ? cfg_wdata : radix_r;
    base_nxt  = base_r;
    rem_nxt   = rem_r;
    pow_nxt   = pow_r;
    idx_nxt   = idx_r;
    dig_nxt   = dig_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    ov_nxt    = ov_r && !out_ready;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          base_nxt = eff_radix(radix_r);
          rem_nxt  = in_value;
          pow_nxt  = VALUE_WIDTH'(1);
          idx_nxt  = '0;
        end
      end
      ST_GROW: begin
        if (grow_ok) begin
          pow_nxt = prod[VALUE_WIDTH-1:0];
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_LOAD: begin
        dig_nxt = '0;
      end
      ST_COUNT: begin
        if (fits) begin
          rem_nxt = rem_r - pq_r;
          dig_nxt = dig_r + 1'b1;
        end else if (emit) begin
          ov_nxt = 1'b1;
          oc_nxt = digit_to_ascii(dig_r);
          ol_nxt = (idx_r == '0);
          if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radix_r <= RADIX_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      radix_r <= radix_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    rem_r  <= rem_nxt;
    pow_r  <= pow_nxt;
    idx_r  <= idx_nxt;
    dig_r  <= dig_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_GROW) begin
      pow_mem[idx_r] <= pow_r;
    end
    pq_r <= pow_mem[idx_r];
  end

  assign out_valid      = ov_r;
  assign out_digit_char = oc_r;
  assign out_last_digit = ol_r;

endmodule
`default_nettype wire

@@ hw/rtl/itrd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to radix digits: port checker
// Watches the ports of the conversion unit and is bound to its top level.
// ----------------------------------------------------------------------------
module itrd_checker
  import itrd_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire [CHAR_W-1:0] out_digit_char,
  input wire              out_last_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
      && $stable(out_last_digit))
    else $error("output word changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 7'h30 && out_digit_char <= 7'h39)
      || (out_digit_char >= 7'h61 && out_digit_char <= 7'h7a))
    else $error("output character outside the digit set");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("unit ready again straight after taking a word");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_last_digit)
    else $error("unit became ready without a final digit pending");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);
`default_nettype wire
